// File: rtl/rlp_enc_pkg.sv
package rlp_enc_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_CONT  = 2'd1,
        OP_LIST  = 2'd2
    } op_t;

    localparam int MAX_RESULTS = 6;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0]  STR_SHORT_BASE  = 8'h80;
    localparam logic [7:0]  STR_LONG_BASE   = 8'hb7;
    localparam logic [7:0]  LIST_SHORT_BASE = 8'hc0;
    localparam logic [7:0]  LIST_LONG_BASE  = 8'hf7;
    localparam logic [31:0] SHORT_LIMIT     = 32'd55;
    localparam logic [7:0]  SINGLE_LIMIT    = 8'd128;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        idx_t        count;
        logic [7:0]  out_byte;
        logic        last;
        logic        error;
        logic [31:0] rem_next;
    } gen_out_t;

endpackage

// File: rtl/rlp_enc_hdr_gen.sv
module rlp_enc_hdr_gen #(
    parameter int MAX_LEN_BYTES = 4
) (
    input  rlp_enc_pkg::op_t      op,
    input  logic [31:0]           length_value,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           bytes_remaining,
    input  rlp_enc_pkg::idx_t     idx,
    output rlp_enc_pkg::gen_out_t gen_out
);

    localparam int LEN_BYTES = (MAX_LEN_BYTES < 4) ? MAX_LEN_BYTES : 4;
    localparam logic [39:0] MAX_LEN_EXT = (40'd1 << (8 * LEN_BYTES)) - 40'd1;

    logic [39:0]       len_ext;
    logic [31:0]       len_sat;
    logic              long_form;
    rlp_enc_pkg::idx_t n_bytes;
    logic [1:0]        sel;
    logic [7:0]        len_byte;

    assign len_ext   = {8'd0, length_value};
    assign len_sat   = (len_ext > MAX_LEN_EXT) ? MAX_LEN_EXT[31:0] : length_value;
    assign long_form = (len_sat > rlp_enc_pkg::SHORT_LIMIT);

    // minimal big-endian length byte count
    always_comb begin
        if (len_sat[31:24] != 8'd0) begin
            n_bytes = rlp_enc_pkg::IDX_W'(4);
        end else if (len_sat[23:16] != 8'd0) begin
            n_bytes = rlp_enc_pkg::IDX_W'(3);
        end else if (len_sat[15:8] != 8'd0) begin
            n_bytes = rlp_enc_pkg::IDX_W'(2);
        end else begin
            n_bytes = rlp_enc_pkg::IDX_W'(1);
        end
    end

    assign sel = 2'(n_bytes - idx);

    always_comb begin
        case (sel)
            2'd0:    len_byte = len_sat[7:0];
            2'd1:    len_byte = len_sat[15:8];
            2'd2:    len_byte = len_sat[23:16];
            default: len_byte = len_sat[31:24];
        endcase
    end

    always_comb begin
        gen_out          = '0;
        gen_out.rem_next = bytes_remaining;
        unique case (op)
            rlp_enc_pkg::OP_START: begin
                gen_out.rem_next = (len_sat == 32'd0) ? 32'd0 : len_sat - 32'd1;
                if (len_sat == 32'd0) begin
                    gen_out.count    = rlp_enc_pkg::IDX_W'(1);
                    gen_out.out_byte = rlp_enc_pkg::STR_SHORT_BASE;
                end else if (len_sat == 32'd1 && data_byte < rlp_enc_pkg::SINGLE_LIMIT) begin
                    gen_out.count    = rlp_enc_pkg::IDX_W'(1);
                    gen_out.out_byte = (data_byte == 8'd0) ? rlp_enc_pkg::STR_SHORT_BASE
                                                           : data_byte;
                end else if (!long_form) begin
                    gen_out.count    = rlp_enc_pkg::IDX_W'(2);
                    gen_out.out_byte = (idx == '0)
                                     ? rlp_enc_pkg::STR_SHORT_BASE + len_sat[7:0]
                                     : data_byte;
                end else begin
                    gen_out.count = n_bytes + rlp_enc_pkg::IDX_W'(2);
                    if (idx == '0) begin
                        gen_out.out_byte = rlp_enc_pkg::STR_LONG_BASE + 8'(n_bytes);
                    end else if (idx == n_bytes + rlp_enc_pkg::IDX_W'(1)) begin
                        gen_out.out_byte = data_byte;
                    end else begin
                        gen_out.out_byte = len_byte;
                    end
                end
            end
            rlp_enc_pkg::OP_CONT: begin
                gen_out.count = rlp_enc_pkg::IDX_W'(1);
                if (bytes_remaining == 32'd0) begin
                    gen_out.error    = 1'b1;
                    gen_out.out_byte = 8'd0;
                end else begin
                    gen_out.out_byte = data_byte;
                    gen_out.rem_next = bytes_remaining - 32'd1;
                end
            end
            rlp_enc_pkg::OP_LIST: begin
                gen_out.rem_next = 32'd0;
                if (!long_form) begin
                    gen_out.count    = rlp_enc_pkg::IDX_W'(1);
                    gen_out.out_byte = rlp_enc_pkg::LIST_SHORT_BASE + len_sat[7:0];
                end else begin
                    gen_out.count    = n_bytes + rlp_enc_pkg::IDX_W'(1);
                    gen_out.out_byte = (idx == '0)
                                     ? rlp_enc_pkg::LIST_LONG_BASE + 8'(n_bytes)
                                     : len_byte;
                end
            end
            default: begin
                gen_out.count = '0;
            end
        endcase
        gen_out.last = (idx == gen_out.count - rlp_enc_pkg::IDX_W'(1));
    end

endmodule

// File: rtl/rlp_item_encoder_top.sv
// channel  | direction | ports
// s_       | in        | s_valid s_ready s_op s_length_value s_data_byte
// m_       | out       | m_valid m_ready m_out_byte m_last m_error
//
// one output byte per cycle unless m_ready stalls the output; an item occupies the
// item register until all its output bytes are emitted: 1 for a continuation or
// single byte, 2 for a short string, up to 6 for a long string header plus first byte
// an unused op code is dropped with no output
// the first m_ byte passes through the item register, then the output register
// aresetn clears the item and output valid flags, the byte index and the remaining count
// m_ready low holds the output register and stalls the item register behind it
module rlp_item_encoder_top #(
    parameter int MAX_LEN_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_length_value,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic        m_error
);

    logic                  item_valid_reg;
    rlp_enc_pkg::op_t      item_op_reg;
    logic [31:0]           item_len_reg;
    logic [7:0]            item_data_reg;
    rlp_enc_pkg::idx_t     idx_reg;
    rlp_enc_pkg::idx_t     idx_next;
    logic [31:0]           rem_reg;
    logic [31:0]           rem_next;
    logic                  m_valid_reg;
    logic [7:0]            m_out_byte_reg;
    logic                  m_last_reg;
    logic                  m_error_reg;

    rlp_enc_pkg::gen_out_t gen_out;
    logic                  out_free;
    logic                  emit;
    logic                  item_done;
    logic                  s_accept;

    rlp_enc_hdr_gen #(
        .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) u_hdr_gen (
        .op              (item_op_reg),
        .length_value    (item_len_reg),
        .data_byte       (item_data_reg),
        .bytes_remaining (rem_reg),
        .idx             (idx_reg),
        .gen_out         (gen_out)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = item_valid_reg && (gen_out.count != '0) && out_free;
    assign item_done = item_valid_reg && ((gen_out.count == '0) || (emit && gen_out.last));
    assign s_ready   = !item_valid_reg || item_done;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        idx_next = idx_reg;
        rem_next = rem_reg;
        if (item_done) begin
            idx_next = '0;
            rem_next = gen_out.rem_next;
        end else if (emit) begin
            idx_next = idx_reg + rlp_enc_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            rem_reg <= rem_next;
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_op_reg   <= rlp_enc_pkg::op_t'(s_op);
            item_len_reg  <= s_length_value;
            item_data_reg <= s_data_byte;
        end
        if (emit) begin
            m_out_byte_reg <= gen_out.out_byte;
            m_last_reg     <= gen_out.last;
            m_error_reg    <= gen_out.error;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;
    assign m_error    = m_error_reg;

    // an error transaction is always a single zero byte closing its item
    a_error_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_error_reg |-> m_last_reg && (m_out_byte_reg == 8'd0))
        else $error("error transaction without last or with nonzero byte");

    // byte index stays inside the current item's byte count
    a_idx_range : assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && (gen_out.count != '0) |-> idx_reg < gen_out.count)
        else $error("byte index beyond item length");

    // a partly emitted item is still held
    a_idx_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> item_valid_reg)
        else $error("nonzero byte index with no item held");

    // a stalled output holds its byte
    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_out_byte_reg)
                                    && $stable(m_last_reg))
        else $error("output register changed under stall");

    // the remaining count only moves when an item completes
    a_rem_update : assert property (@(posedge aclk) disable iff (!aresetn)
        !item_done |=> $stable(rem_reg))
        else $error("remaining count changed without item completion");

endmodule

// File: test/rlp_item_encoder_checker.sv
`timescale 1ns / 100ps

module rlp_item_encoder_checker #(
    parameter int LEN_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_length_value,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_last,
    input  logic        m_error,
    output int          mismatch_count,
    output int          bytes_pending
);

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } enc_byte_t;

    enc_byte_t   encoded_q[$];
    logic [31:0] payload_left;
    int          mismatches;

    function automatic logic [31:0] clamp_len(input logic [31:0] len);
        logic [63:0] ceiling;
        ceiling = (64'd1 << (8 * ((LEN_BYTES < 4) ? LEN_BYTES : 4))) - 64'd1;
        return (64'(len) > ceiling) ? ceiling[31:0] : len;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input logic error);
        enc_byte_t e;
        e.out_byte = b;
        e.last     = last;
        e.error    = error;
        encoded_q  = {encoded_q, e};
    endtask

    // prefix with byte count, then minimal big-endian length
    task automatic push_length_header(input logic [7:0] base, input logic [31:0] len,
                                      input logic last_on_final);
        int n;
        n = 1;
        while (n < 4 && (len >> (8 * n)) != 0)
            n++;
        push_byte(base + 8'(n), 1'b0, 1'b0);
        for (int i = n - 1; i >= 0; i--)
            push_byte(8'(len >> (8 * i)), last_on_final && (i == 0), 1'b0);
    endtask

    task automatic predict_encoding(input logic [1:0] op, input logic [31:0] len_in,
                                    input logic [7:0] d);
        logic [31:0] len;
        len = clamp_len(len_in);
        case (op)
            rlp_enc_pkg::OP_START: begin
                if (len == 0) begin
                    push_byte(rlp_enc_pkg::STR_SHORT_BASE, 1'b1, 1'b0);
                    payload_left = '0;
                end else begin
                    if (len == 1 && d == 8'd0) begin
                        push_byte(rlp_enc_pkg::STR_SHORT_BASE, 1'b1, 1'b0);
                    end else if (len == 1 && d < rlp_enc_pkg::SINGLE_LIMIT) begin
                        push_byte(d, 1'b1, 1'b0);
                    end else begin
                        if (len <= rlp_enc_pkg::SHORT_LIMIT)
                            push_byte(rlp_enc_pkg::STR_SHORT_BASE + len[7:0], 1'b0, 1'b0);
                        else
                            push_length_header(rlp_enc_pkg::STR_LONG_BASE, len, 1'b0);
                        push_byte(d, 1'b1, 1'b0);
                    end
                    payload_left = len - 1;
                end
            end
            rlp_enc_pkg::OP_CONT: begin
                if (payload_left == 0) begin
                    push_byte(8'd0, 1'b1, 1'b1);
                end else begin
                    push_byte(d, 1'b1, 1'b0);
                    payload_left = payload_left - 1;
                end
            end
            rlp_enc_pkg::OP_LIST: begin
                if (len <= rlp_enc_pkg::SHORT_LIMIT)
                    push_byte(rlp_enc_pkg::LIST_SHORT_BASE + len[7:0], 1'b1, 1'b0);
                else
                    push_length_header(rlp_enc_pkg::LIST_LONG_BASE, len, 1'b1);
                payload_left = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        enc_byte_t e;
        if (!aresetn) begin
            encoded_q.delete();
            payload_left = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (encoded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected none, got byte %02h last %b error %b",
                             $time, m_out_byte, m_last, m_error);
                end else begin
                    e = encoded_q.pop_front();
                    if (m_out_byte !== e.out_byte || m_last !== e.last
                            || m_error !== e.error) begin
                        mismatches++;
                        $display("%0t: expected byte %02h last %b error %b, %s",
                                 $time, e.out_byte, e.last, e.error, "got");
                        $display("%0t:   got byte %02h last %b error %b",
                                 $time, m_out_byte, m_last, m_error);
                    end
                end
            end
            if (s_valid && s_ready)
                predict_encoding(s_op, s_length_value, s_data_byte);
        end
        mismatch_count <= mismatches;
        bytes_pending  <= encoded_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int         LEN_BYTES      = 4;
    localparam int         RANDOM_ITEMS   = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 20;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op           = rlp_enc_pkg::OP_START;
    logic [31:0] s_length_value = '0;
    logic [7:0]  s_data_byte    = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        m_error;

    int mismatch_count;
    int bytes_pending;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int quiet_cycles = 0;

    rlp_item_encoder_top #(
        .MAX_LEN_BYTES(LEN_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_length_value(s_length_value),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_error       (m_error)
    );

    rlp_item_encoder_checker #(
        .LEN_BYTES(LEN_BYTES)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_length_value(s_length_value),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_error       (m_error),
        .mismatch_count(mismatch_count),
        .bytes_pending (bytes_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_phase(input int phase);
        case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 74; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 74; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input logic [31:0] len, input logic [7:0] d);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_length_value <= len;
        s_data_byte    <= d;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // spread lengths over every byte width
    function automatic logic [31:0] wide_len();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    initial begin
        logic [31:0] len;
        int unsigned conts;
        int          pick;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_phase(0);
        send_item(rlp_enc_pkg::OP_START, 32'd0, 8'hff);
        send_item(rlp_enc_pkg::OP_START, 32'd1, 8'h00);
        send_item(rlp_enc_pkg::OP_START, 32'd1, 8'h7f);
        send_item(rlp_enc_pkg::OP_START, 32'd1, 8'h80);
        send_item(rlp_enc_pkg::OP_CONT, 32'hffffffff, 8'hff);
        send_item(rlp_enc_pkg::OP_START, 32'd2, 8'hab);
        send_item(rlp_enc_pkg::OP_CONT, 32'd0, 8'h00);
        send_item(rlp_enc_pkg::OP_CONT, 32'd0, 8'h55);
        send_item(rlp_enc_pkg::OP_START, 32'd55, 8'h01);
        send_item(rlp_enc_pkg::OP_START, 32'd56, 8'hfe);
        send_item(rlp_enc_pkg::OP_LIST, 32'd0, 8'h00);
        send_item(rlp_enc_pkg::OP_CONT, 32'd0, 8'h33);
        send_item(rlp_enc_pkg::OP_LIST, 32'd55, 8'h00);
        send_item(rlp_enc_pkg::OP_LIST, 32'd56, 8'h00);
        send_item(rlp_enc_pkg::OP_LIST, 32'hffffffff, 8'hff);
        send_item(rlp_enc_pkg::OP_START, 32'h100, 8'h10);
        send_item(rlp_enc_pkg::OP_START, 32'hffff, 8'h20);
        send_item(rlp_enc_pkg::OP_START, 32'h10000, 8'h30);
        send_item(rlp_enc_pkg::OP_START, 32'hffffff, 8'h40);
        send_item(rlp_enc_pkg::OP_START, 32'h1000000, 8'h50);
        send_item(rlp_enc_pkg::OP_START, 32'hffffffff, 8'hff);
        send_item(rlp_enc_pkg::OP_CONT, 32'd0, 8'h5a);
        send_item(OP_UNUSED, 32'hffffffff, 8'hff);
        send_item(rlp_enc_pkg::OP_CONT, 32'd0, 8'ha5);
        send_item(rlp_enc_pkg::OP_LIST, 32'h100, 8'h00);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            set_phase(items_sent * 4 / RANDOM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) == 0)
                    len = wide_len();
                else if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(0, 60);
                else
                    len = $urandom_range(0, 12);
                send_item(rlp_enc_pkg::OP_START, len, 8'($urandom_range(0, 255)));
                if (len > 64)
                    conts = $urandom_range(0, 4);
                else
                    conts = (len == 0) ? 0 : len - 1;
                if (len <= 64 && $urandom_range(0, 6) == 0)
                    conts = $urandom_range(0, conts);
                else if ($urandom_range(0, 9) == 0)
                    conts++;
                repeat (conts)
                    send_item(rlp_enc_pkg::OP_CONT, $urandom, 8'($urandom_range(0, 255)));
            end else if (pick < 72) begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 70) : wide_len();
                send_item(rlp_enc_pkg::OP_LIST, len, 8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                send_item(rlp_enc_pkg::OP_CONT, $urandom, 8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                send_item(OP_UNUSED, $urandom, 8'($urandom_range(0, 255)));
            end else begin
                send_item(rlp_enc_pkg::OP_START, $urandom, 8'($urandom_range(0, 255)));
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (bytes_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (bytes_pending != 0)
            $display("%0t: %0d expected output bytes never arrived", $time, bytes_pending);
        if (mismatch_count == 0 && bytes_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
